FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Request codes, field widths and the value reported for a missing element.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int OCC_W  = 11;
    localparam int FLAG_W = 3;

    // tdata of the result: popped, front, back, occupancy, padded to bytes
    localparam int OUT_DATA_RAW_W = 3 * DATA_W + OCC_W;
    localparam int OUT_DATA_W     = ((OUT_DATA_RAW_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] NONE_VALUE = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY      = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4
    } t_req;

endpackage
`default_nettype wire

FILE: rtl/core/deq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_mem: element storage of the double-ended queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module deq_mem
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: ring control of the double-ended queue
// Holds head, tail, count and cached end values; reads the new end element,
// commits the update and loads the result register.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int IW          = 10,
    parameter int CW          = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request side
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire logic [REQ_W-1:0]  i_req,
    input  wire logic [DATA_W-1:0] i_val,
    // storage ports
    output logic                   o_we,
    output logic      [IW-1:0]     o_waddr,
    output logic      [DATA_W-1:0] o_wdata,
    output logic                   o_re,
    output logic      [IW-1:0]     o_raddr,
    input  wire logic [DATA_W-1:0] i_rdata,
    // result side
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output logic      [DATA_W-1:0] o_popped,
    output logic                   o_pop_ok,
    output logic                   o_push_dropped,
    output logic      [DATA_W-1:0] o_front,
    output logic      [DATA_W-1:0] o_back,
    output logic      [OCC_W-1:0]  o_occupancy,
    output logic                   o_is_empty
);

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i_idx);
        if (i_idx == IW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return i_idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] i_idx);
        if (i_idx == '0) begin
            return IW'(QUEUE_DEPTH - 1);
        end
        return i_idx - 1'b1;
    endfunction

    t_state            r_state;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_back, n_back;
    t_req              r_req;
    logic [DATA_W-1:0] r_val;

    logic              r_m_valid;
    logic [DATA_W-1:0] r_popped;
    logic              r_pop_ok;
    logic              r_dropped;
    logic [DATA_W-1:0] r_front_out;
    logic [DATA_W-1:0] r_back_out;
    logic [OCC_W-1:0]  r_occ;
    logic              r_empty;

    logic              c_accept;
    logic              c_commit;
    logic              c_full;
    logic              c_we;
    logic [IW-1:0]     c_waddr;
    logic [DATA_W-1:0] c_popped;
    logic              c_pop_ok;
    logic              c_dropped;

    assign o_s_ready = (r_state == S_IDLE);
    assign c_accept  = i_s_valid && o_s_ready;
    assign c_commit  = (r_state == S_COMMIT) && (!r_m_valid || i_m_ready);
    assign c_full    = (r_count == CW'(QUEUE_DEPTH));

    // fetch the element that becomes the new end after a pop
    assign o_re    = c_accept;
    assign o_raddr = (t_req'(i_req) == REQ_POP_BACK) ? f_prev(f_prev(r_tail))
                                                     : f_next(r_head);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_front   = r_front;
        n_back    = r_back;
        c_we      = 1'b0;
        c_waddr   = r_tail;
        c_popped  = NONE_VALUE;
        c_pop_ok  = 1'b0;
        c_dropped = 1'b0;
        unique case (r_req)
            REQ_PUSH_FRONT: begin
                if (c_full) begin
                    c_dropped = 1'b1;
                end else begin
                    n_head  = f_prev(r_head);
                    c_we    = 1'b1;
                    c_waddr = n_head;
                    n_count = r_count + 1'b1;
                    n_front = r_val;
                    if (r_count == '0) begin
                        n_back = r_val;
                    end
                end
            end
            REQ_PUSH_BACK: begin
                if (c_full) begin
                    c_dropped = 1'b1;
                end else begin
                    n_tail  = f_next(r_tail);
                    c_we    = 1'b1;
                    c_waddr = r_tail;
                    n_count = r_count + 1'b1;
                    n_back  = r_val;
                    if (r_count == '0) begin
                        n_front = r_val;
                    end
                end
            end
            REQ_POP_FRONT: begin
                if (r_count != '0) begin
                    c_popped = r_front;
                    c_pop_ok = 1'b1;
                    n_head   = f_next(r_head);
                    n_count  = r_count - 1'b1;
                    n_front  = i_rdata;
                end
            end
            REQ_POP_BACK: begin
                if (r_count != '0) begin
                    c_popped = r_back;
                    c_pop_ok = 1'b1;
                    n_tail   = f_prev(r_tail);
                    n_count  = r_count - 1'b1;
                    n_back   = i_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_we    = c_we && c_commit;
    assign o_waddr = c_waddr;
    assign o_wdata = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // load on commit, otherwise hold until the receiver takes it
            r_m_valid <= c_commit || (r_m_valid && !i_m_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (c_accept) begin
                        r_req   <= t_req'(i_req);
                        r_val   <= i_val;
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (c_commit) begin
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_count     <= n_count;
                        r_front     <= n_front;
                        r_back      <= n_back;
                        r_popped    <= c_popped;
                        r_pop_ok    <= c_pop_ok;
                        r_dropped   <= c_dropped;
                        r_front_out <= (n_count == '0) ? NONE_VALUE : n_front;
                        r_back_out  <= (n_count == '0) ? NONE_VALUE : n_back;
                        r_occ       <= OCC_W'(n_count);
                        r_empty     <= (n_count == '0);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_valid      = r_m_valid;
    assign o_popped       = r_popped;
    assign o_pop_ok       = r_pop_ok;
    assign o_push_dropped = r_dropped;
    assign o_front        = r_front_out;
    assign o_back         = r_back_out;
    assign o_occupancy    = r_occ;
    assign o_is_empty     = r_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("deque count exceeds depth");

    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty deque with head and tail apart");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_m_valid && !i_m_ready)
        |=> (r_state == S_COMMIT && $stable(r_count) && $stable(r_head)))
        else $error("commit taken while result register blocked");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("storage read and write in the same cycle");

endmodule
`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit values in a ring buffer
//
// Input stream: s_axis_tuser carries the request code (query, push front,
// push back, pop front, pop back; unused codes act as a query) and
// s_axis_tdata the value to push. Every request yields exactly one result on
// the output stream: the popped value and flags, plus the front value, back
// value and occupancy as they stand after the request.
//
// Timing: a request is accepted in S_IDLE, the storage read for the
// element that becomes the new end is issued at that edge, and the update
// commits from S_COMMIT into the result register once that register is free.
// A new request is not accepted until the previous one has committed; the
// result then appears on m_axis from the result register.
//
// Stall: the result register holds until taken. A new request is accepted
// while a result waits; its commit holds until the register frees.
// Reset: synchronous, active low; the queue starts empty. Storage contents
// are not cleared, only occupied entries are ever reported.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DATA_W-1:0]     s_axis_tdata,  // [31:0] item_value
    input  wire logic [REQ_W-1:0]      s_axis_tuser,  // [2:0] req_type
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
    // [106:96] occupancy, upper bits zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] pop_ok, [1] push_dropped, [2] is_empty
    output logic      [FLAG_W-1:0]     m_axis_tuser
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;

    logic [DATA_W-1:0] w_popped;
    logic              w_pop_ok;
    logic              w_dropped;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_back;
    logic [OCC_W-1:0]  w_occ;
    logic              w_empty;

    // ring storage, one write and one registered read per cycle
    deq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // index, count and end-value bookkeeping plus result register
    deq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (s_axis_tvalid),
        .o_s_ready      (s_axis_tready),
        .i_req          (s_axis_tuser),
        .i_val          (s_axis_tdata),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_re           (w_re),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_popped       (w_popped),
        .o_pop_ok       (w_pop_ok),
        .o_push_dropped (w_dropped),
        .o_front        (w_front),
        .o_back         (w_back),
        .o_occupancy    (w_occ),
        .o_is_empty     (w_empty)
    );

    // pack result fields, lowest field first, zero padding on top
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_DATA_RAW_W){1'b0}},
                           w_occ, w_back, w_front, w_popped};
    assign m_axis_tuser = {w_empty, w_dropped, w_pop_ok};

endmodule
`default_nettype wire

FILE: test/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the ring-buffer deque
// Drives requests on the input stream with bursts and gaps and stalls the
// result stream on a changing pattern. A local ring model predicts every
// status word, and each result transaction is checked field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int QDEPTH  = 1024;
    localparam int CLK_HI  = 6;
    localparam int CLK_LO  = 6;
    localparam int RUN_CAP = 5_000_000;   // ns, far above the slowest clean run

    // spare request codes, answered like a query
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    // bit positions in m_axis_tuser
    localparam int FLAG_POP_OK  = 0;
    localparam int FLAG_DROPPED = 1;
    localparam int FLAG_EMPTY   = 2;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        logic              pop_ok;
        logic              dropped;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] back;
        logic [OCC_W-1:0]  occ;
        logic              empty;
    } t_deq_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;   // [31:0] item_value
    logic [REQ_W-1:0]      s_axis_tuser = '0;   // [2:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] popped, [63:32] front, [95:64] back, [106:96] occupancy
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] pop_ok, [1] push_dropped, [2] is_empty
    logic [FLAG_W-1:0]     m_axis_tuser;

    // ring model of the deque
    logic [DATA_W-1:0] ring_mem [QDEPTH];
    int                ring_head = 0;
    int                ring_tail = 0;
    int                ring_count = 0;

    t_deq_status status_due [$];
    int          fail_count = 0;

    // sender pacing and receiver stall control
    int burst_left = 0;
    int gap_max = 4;
    int rx_hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_phase = 0;

    double_ended_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HI i_clk = 1'b1;
        #CLK_LO i_clk = 1'b0;
    end

    initial begin
        #RUN_CAP;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int ring_prev(int idx);
        return (idx + QDEPTH - 1) % QDEPTH;
    endfunction

    // Apply one request to the ring model and return the status it yields.
    function automatic t_deq_status apply_request(logic [REQ_W-1:0] code,
                                                  logic [DATA_W-1:0] val);
        t_deq_status st;
        st = '{popped: NONE_VALUE, pop_ok: 1'b0, dropped: 1'b0,
               front: NONE_VALUE, back: NONE_VALUE, occ: '0, empty: 1'b0};
        case (code)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (ring_count >= QDEPTH) begin
                    st.dropped = 1'b1;
                end else if (code == REQ_PUSH_FRONT) begin
                    ring_head = ring_prev(ring_head);
                    ring_mem[ring_head] = val;
                    ring_count++;
                end else begin
                    ring_mem[ring_tail] = val;
                    ring_tail = (ring_tail + 1) % QDEPTH;
                    ring_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (ring_count != 0) begin
                    if (code == REQ_POP_FRONT) begin
                        st.popped = ring_mem[ring_head];
                        ring_head = (ring_head + 1) % QDEPTH;
                    end else begin
                        ring_tail = ring_prev(ring_tail);
                        st.popped = ring_mem[ring_tail];
                    end
                    ring_count--;
                    st.pop_ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (ring_count != 0) begin
            st.front = ring_mem[ring_head];
            st.back  = ring_mem[ring_prev(ring_tail)];
        end
        st.occ   = OCC_W'(ring_count);
        st.empty = (ring_count == 0);
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Check result transactions first, then predict for the accepted request;
    // a result never belongs to a request taken at the same edge.
    always @(posedge i_clk) begin
        t_deq_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_due.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = status_due[0];
                status_due.delete(0);
                check_field("popped", m_axis_tdata[DATA_W-1:0], want.popped);
                check_field("front", m_axis_tdata[2*DATA_W-1:DATA_W], want.front);
                check_field("back", m_axis_tdata[3*DATA_W-1:2*DATA_W], want.back);
                check_field("occupancy", DATA_W'(m_axis_tdata[3*DATA_W+:OCC_W]),
                            DATA_W'(want.occ));
                check_field("tdata pad", DATA_W'(m_axis_tdata >> OUT_DATA_RAW_W), '0);
                check_field("pop_ok", DATA_W'(m_axis_tuser[FLAG_POP_OK]),
                            DATA_W'(want.pop_ok));
                check_field("push_dropped", DATA_W'(m_axis_tuser[FLAG_DROPPED]),
                            DATA_W'(want.dropped));
                check_field("is_empty", DATA_W'(m_axis_tuser[FLAG_EMPTY]),
                            DATA_W'(want.empty));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            status_due.insert(status_due.size(),
                              apply_request(s_axis_tuser, s_axis_tdata));
    end

    // Receiver: honor a forced hold first, otherwise run the current pattern.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_phase % 3) != 0;
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
        rx_phase++;
    end

    // Offer one request and hold it until the block takes it. Open a gap
    // of random length whenever the current burst runs out.
    task automatic send_req(input logic [REQ_W-1:0] code, input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                s_axis_tuser  <= REQ_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= code;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Pause the sender until every outstanding result has been taken.
    task automatic wait_results_drained();
        idle_sender();
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] rand_push();
        return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    endfunction

    function automatic logic [REQ_W-1:0] rand_pop();
        return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
    endfunction

    // Empty-queue pops, value extremes, single-element ends, spare codes.
    task automatic test_directed_cases();
        send_req(REQ_QUERY, 32'hdead_beef);
        send_req(REQ_POP_FRONT, '1);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_PUSH_FRONT, 32'h8000_0000);
        send_req(REQ_PUSH_BACK, 32'h7fff_ffff);
        send_req(REQ_QUERY, '0);
        send_req(REQ_PUSH_FRONT, '1);
        send_req(REQ_PUSH_BACK, '0);
        send_req(REQ_PUSH_BACK, 32'haaaa_5555);
        send_req(REQ_SPARE_5, 32'h5555_aaaa);
        send_req(REQ_SPARE_6, '1);
        send_req(REQ_SPARE_7, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_BACK, '1);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_BACK, '0);
        // single element: front and back are the same entry
        send_req(REQ_PUSH_BACK, 32'h0000_0001);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_PUSH_FRONT, 32'hffff_fffe);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_QUERY, '0);
        wait_results_drained();
    endtask

    // Fill to capacity, push into the full queue, then pop a few from
    // either end.
    task automatic test_full_queue();
        gap_max = 1;
        while (ring_count < QDEPTH) begin
            if (ring_count == QDEPTH / 2)
                rx_hold_left = 500;
            send_req(rand_push(), $urandom);
        end
        send_req(REQ_PUSH_FRONT, $urandom);
        send_req(REQ_PUSH_BACK, $urandom);
        send_req(REQ_QUERY, $urandom);
        send_req(REQ_POP_FRONT, $urandom);
        send_req(REQ_POP_BACK, $urandom);
        send_req(REQ_PUSH_BACK, $urandom);
        send_req(REQ_PUSH_FRONT, $urandom);
        send_req(REQ_PUSH_BACK, $urandom);
        repeat (16)
            send_req(rand_pop(), $urandom);
        wait_results_drained();
    endtask

    // Hold the result stream for a long stretch while requests keep coming,
    // so the block backs up and stalls its input.
    task automatic test_receiver_hold();
        gap_max = 0;
        rx_hold_left = 300;
        repeat (40) begin
            if (ring_count < 8)
                send_req(rand_push(), rand_value());
            else
                send_req($urandom_range(0, 2) ? rand_pop() : REQ_QUERY, rand_value());
        end
        wait_results_drained();
    endtask

    // Random mix steered around a moving occupancy goal, with some noise.
    task automatic test_random_traffic(input int n_items);
        int goal;
        int roll;
        goal = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 7))
                    0: goal = 0;
                    1: goal = $urandom_range(50, 200);
                    default: goal = $urandom_range(1, 24);
                endcase
            end
            if (i % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 2;
                    default: gap_max = 6;
                endcase
            end
            if (i == n_items / 3)
                wait_results_drained();
            if (i == 2 * n_items / 3)
                rx_hold_left = 150;
            roll = $urandom_range(0, 99);
            if (roll < 6)
                send_req(REQ_SPARE_5 + REQ_W'($urandom_range(0, 2)), rand_value());
            else if (roll < 14)
                send_req(REQ_QUERY, rand_value());
            else if ((ring_count < goal) ? (roll < 75) : (roll >= 75))
                send_req(rand_push(), rand_value());
            else
                send_req(rand_pop(), rand_value());
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_full_queue();
        test_receiver_hold();
        test_random_traffic(250);

        // let any stray result surface before the verdict
        repeat (10) @(posedge i_clk);
        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", status_due.size()));
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_mem.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue.sv
test/double_ended_queue_tb.sv
